// ----- rtl/deqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_pkg: shared types and constants for the deque with search
// Operation and status codes, sequencer states and the control/status
// structs that pass between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package deqs_pkg;

  // field widths fixed by the word format
  localparam int unsigned ModeW = 3;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned StsW  = 2;
  localparam int unsigned OccW  = 5;

  // operation codes; the two spare codes are no-ops
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_FIND       = 3'd5
  } mode_e;

  // result status codes
  typedef enum logic [StsW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_FIND = 2'd2
  } state_e;

  // sequencer to scan unit
  typedef struct packed {
    logic start;  // load key and pointers, first read issued by sequencer
    logic step;   // advance to the next stored entry
  } scan_cmd_t;

  // scan unit to sequencer
  typedef struct packed {
    logic hit;    // current entry equals the key
    logic last;   // current entry is the back of the queue
  } scan_sts_t;

endpackage

// ----- rtl/deqs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_in_if / deqs_out_if: valid/ready channels of the deque
// Command words in, result words out.
// ----------------------------------------------------------------------------
interface deqs_in_if;
  logic                          valid;
  logic                          ready;
  logic [deqs_pkg::ModeW-1:0]    mode;
  logic signed [deqs_pkg::WordW-1:0] value_in;

  modport source (output valid, output mode, output value_in, input ready);
  modport sink   (input valid, input mode, input value_in, output ready);
endinterface

interface deqs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [deqs_pkg::WordW-1:0] value_out;
  logic                              found;
  logic [deqs_pkg::PosW-1:0]         position;
  logic [deqs_pkg::StsW-1:0]         status;
  logic [deqs_pkg::OccW-1:0]         occupancy;

  modport source (output valid, output value_out, output found, output position,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input value_out, input found, input position,
                  input status, input occupancy, output ready);
endinterface

// ----- rtl/double_ended_queue_with_search_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_search_unit: bounded deque of 32-bit words
// Ring store of DEPTH words with push/pop at both ends, clear and find.
// ----------------------------------------------------------------------------
// Each command word gives one result word. Pushes, clear, refused pops and
// the spare codes finish in the accept cycle (result registered at that
// edge). A pop issues its read in the accept cycle and loads the result
// from the registered read port in the S_POP state. Find walks the queue
// from the front with a single compare unit, one stored word per cycle
// through the one read port and stops at the first match or at the back
// of the queue; an empty queue gives a miss in the accept cycle. The block
// takes a new command when the sequencer is idle and the output register is
// free or being drained in the same cycle. The store needs no clearing pass
// after reset; only words that were pushed are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deqs_in_if.sink    in_i,
  deqs_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  deqs_pkg::state_e state_q, state_d;
  logic [AW-1:0]    front_q, front_d;
  logic [AW-1:0]    back_q, back_d;
  logic [CW-1:0]    count_q, count_d;

  logic                              out_valid_q, out_valid_d;
  logic [deqs_pkg::WordW-1:0]        value_q, value_d;
  logic                              found_q, found_d;
  logic [AW-1:0]                     pos_q, pos_d;
  deqs_pkg::status_e                 status_q, status_d;
  logic                              load_out;

  logic                 in_fire;
  deqs_pkg::mode_e      mode;
  logic                 empty, full;
  logic [AW-1:0]        front_prev, front_next, back_prev, back_next;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [deqs_pkg::WordW-1:0] ram_rdata;

  deqs_pkg::scan_cmd_t  scan_cmd;
  deqs_pkg::scan_sts_t  scan_sts;
  logic [AW-1:0]        scan_raddr;
  logic [AW-1:0]        scan_pos;

  logic [AW+deqs_pkg::PosW-1:0] pos_ext;
  logic [CW+deqs_pkg::OccW-1:0] occ_ext;

  // handshake
  assign in_i.ready = (state_q == deqs_pkg::S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign mode       = deqs_pkg::mode_e'(in_i.mode);

  // ring neighbors of the end pointers
  assign front_prev = (front_q == '0) ? AW'(DEPTH-1) : front_q - 1'b1;
  assign front_next = (front_q == AW'(DEPTH-1)) ? '0 : front_q + 1'b1;
  assign back_prev  = (back_q == '0) ? AW'(DEPTH-1) : back_q - 1'b1;
  assign back_next  = (back_q == AW'(DEPTH-1)) ? '0 : back_q + 1'b1;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CW'(DEPTH));

  // sequencer: next state, store access and result capture
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = back_q;
    ram_re    = 1'b0;
    ram_raddr = front_q;
    scan_cmd  = '0;
    load_out  = 1'b0;
    value_d   = '0;
    found_d   = 1'b0;
    pos_d     = '0;
    status_d  = deqs_pkg::ST_DONE;

    unique case (state_q)
      deqs_pkg::S_IDLE: begin
        if (in_fire) begin
          case (mode)
            deqs_pkg::MODE_PUSH_FRONT: begin
              load_out = 1'b1;
              if (full) begin
                status_d = deqs_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_prev;
                front_d   = front_prev;
                count_d   = count_q + 1'b1;
              end
            end
            deqs_pkg::MODE_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                status_d = deqs_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = back_q;
                back_d    = back_next;
                count_d   = count_q + 1'b1;
              end
            end
            deqs_pkg::MODE_POP_FRONT: begin
              if (empty) begin
                load_out = 1'b1;
                status_d = deqs_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                front_d   = front_next;
                count_d   = count_q - 1'b1;
                state_d   = deqs_pkg::S_POP;
              end
            end
            deqs_pkg::MODE_POP_BACK: begin
              if (empty) begin
                load_out = 1'b1;
                status_d = deqs_pkg::ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = back_prev;
                back_d    = back_prev;
                count_d   = count_q - 1'b1;
                state_d   = deqs_pkg::S_POP;
              end
            end
            deqs_pkg::MODE_CLEAR: begin
              load_out = 1'b1;
              front_d  = '0;
              back_d   = '0;
              count_d  = '0;
            end
            deqs_pkg::MODE_FIND: begin
              if (empty) begin
                load_out = 1'b1;
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = front_q;
                scan_cmd.start = 1'b1;
                state_d        = deqs_pkg::S_FIND;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      deqs_pkg::S_POP: begin
        load_out = 1'b1;
        value_d  = ram_rdata;
        state_d  = deqs_pkg::S_IDLE;
      end
      deqs_pkg::S_FIND: begin
        if (scan_sts.hit) begin
          load_out = 1'b1;
          found_d  = 1'b1;
          pos_d    = scan_pos;
          state_d  = deqs_pkg::S_IDLE;
        end else if (scan_sts.last) begin
          load_out = 1'b1;
          state_d  = deqs_pkg::S_IDLE;
        end else begin
          ram_re        = 1'b1;
          ram_raddr     = scan_raddr;
          scan_cmd.step = 1'b1;
        end
      end
      default: begin
        state_d = deqs_pkg::S_IDLE;
      end
    endcase
  end

  // output valid follows load and drain
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deqs_pkg::S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register; occupancy is taken live from the count
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q  <= value_d;
      found_q  <= found_d;
      pos_q    <= pos_d;
      status_q <= status_d;
    end
  end

  // word store
  deqs_ram #(
    .WIDTH (deqs_pkg::WordW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.value_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search unit
  deqs_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scan_cmd),
    .key_i   (in_i.value_in),
    .front_i (front_q),
    .count_i (count_q),
    .rdata_i (ram_rdata),
    .raddr_o (scan_raddr),
    .pos_o   (scan_pos),
    .sts_o   (scan_sts)
  );

  // output word, position and occupancy masked to field widths
  assign pos_ext         = {{deqs_pkg::PosW{1'b0}}, pos_q};
  assign occ_ext         = {{deqs_pkg::OccW{1'b0}}, count_q};
  assign out_o.valid     = out_valid_q;
  assign out_o.value_out = value_q;
  assign out_o.found     = found_q;
  assign out_o.position  = pos_ext[deqs_pkg::PosW-1:0];
  assign out_o.status    = status_q;
  assign out_o.occupancy = occ_ext[deqs_pkg::OccW-1:0];

  // count never passes the store depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // a multi-cycle operation only runs with the output register free
  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != deqs_pkg::S_IDLE) |-> !out_valid_q)
    else $error("result register busy during pop or find");

  // an accepted push into a non-full queue grows the count by one
  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !full && (mode == deqs_pkg::MODE_PUSH_FRONT ||
                          mode == deqs_pkg::MODE_PUSH_BACK))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not grow the count");

endmodule

// ----- rtl/deqs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/deqs_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deqs_scan: search unit of the deque
// One 32-bit equality compare reused each cycle on the word read from the
// store, with the ring read pointer and the offset counter of the walk.
// ----------------------------------------------------------------------------
module deqs_scan #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deqs_pkg::scan_cmd_t               cmd_i,
  input  logic [deqs_pkg::WordW-1:0]        key_i,
  input  logic [$clog2(DEPTH)-1:0]          front_i,
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  logic [deqs_pkg::WordW-1:0]        rdata_i,
  output logic [$clog2(DEPTH)-1:0]          raddr_o,
  output logic [$clog2(DEPTH)-1:0]          pos_o,
  output deqs_pkg::scan_sts_t               sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [deqs_pkg::WordW-1:0] key_q;
  logic [AW-1:0]              idx_q, idx_d;
  logic [AW-1:0]              ofs_q, ofs_d;
  logic [AW-1:0]              idx_base;
  logic [AW-1:0]              idx_next;
  logic [CW-1:0]              ofs_ext;

  // ring increment of the read pointer
  assign idx_base = cmd_i.start ? front_i : idx_q;
  assign idx_next = (idx_base == AW'(DEPTH-1)) ? '0 : idx_base + 1'b1;

  // pointer and offset update
  always_comb begin
    idx_d = idx_q;
    ofs_d = ofs_q;
    if (cmd_i.start) begin
      idx_d = idx_next;
      ofs_d = '0;
    end else if (cmd_i.step) begin
      idx_d = idx_next;
      ofs_d = ofs_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ofs_q <= '0;
    end else begin
      idx_q <= idx_d;
      ofs_q <= ofs_d;
    end
  end

  // search key
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
    end
  end

  // shared compare, and end-of-queue check
  assign ofs_ext    = CW'(ofs_q);
  assign sts_o.hit  = (rdata_i == key_q);
  assign sts_o.last = ((ofs_ext + CW'(1)) == count_i);
  assign raddr_o    = idx_q;
  assign pos_o      = ofs_q;

endmodule
